// File: design/bsda_pkg.sv
`timescale 1ns / 1ps

package bsda_pkg;

    localparam int BTN_W  = 8;

    // req_type codes
    localparam logic REQ_SCAN   = 1'b0;
    localparam logic REQ_CANCEL = 1'b1;

    // Register indexes on the config port
    typedef enum logic [2:0] {
        CFG_BUTTON_MASK   = 3'd0,
        CFG_AUTOREPEAT    = 3'd1,
        CFG_FILTER_DEPTH  = 3'd2,
        CFG_LONG_PRESS    = 3'd3,
        CFG_FIRST_DELAY   = 3'd4,
        CFG_START_PERIOD  = 3'd5,
        CFG_MIN_PERIOD    = 3'd6,
        CFG_IDLE_TIMEOUT  = 3'd7
    } t_cfg_idx;

    localparam logic [7:0]  RST_BUTTON_MASK  = 8'd255;
    localparam logic [7:0]  RST_AUTOREPEAT   = 8'd0;
    localparam logic [3:0]  RST_FILTER_DEPTH = 4'd4;
    localparam logic [7:0]  RST_LONG_PRESS   = 8'd50;
    localparam logic [7:0]  RST_FIRST_DELAY  = 8'd60;
    localparam logic [7:0]  RST_START_PERIOD = 8'd12;
    localparam logic [7:0]  RST_MIN_PERIOD   = 8'd5;
    localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd3000;

    // Accelerator: first shrink after six repeats, then every four
    localparam logic [2:0] ACCEL_FIRST  = 3'd6;
    localparam logic [2:0] ACCEL_RELOAD = 3'd4;

    typedef struct packed {
        logic [7:0]  button_mask;
        logic [7:0]  autorepeat_mask;
        logic [3:0]  filter_depth;
        logic [7:0]  long_press_ticks;
        logic [7:0]  repeat_first_delay;
        logic [7:0]  repeat_start_period;
        logic [7:0]  repeat_min_period;
        logic [15:0] idle_timeout;
    } t_cfg;

    typedef struct packed {
        logic [7:0] btn_held;
        logic [7:0] btn_press;
        logic [7:0] btn_release;
        logic [7:0] buttons_long;
        logic       idle_expired;
        logic [7:0] last_pressed;
    } t_result;

    // Bits of the sample that carry a button
    function automatic logic [BTN_W-1:0] lane_mask(input int count);
        logic [BTN_W-1:0] m;
        for (int i = 0; i < BTN_W; i++) begin
            m[i] = (i < count);
        end
        return m;
    endfunction

endpackage

// File: design/button_scan_debounce_autorepeat.sv
`timescale 1ns / 1ps
// Channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// input    | i_in_valid / o_in_ready    | i_req_type, i_button_sample
// output   | o_out_valid / i_out_ready  | o_btn_held .. o_last_pressed
// config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled. An accepted item
// lands in the input register, is processed once the output register is free,
// and its result is registered in the output register, which raises o_out_valid.
// A scan tick gives one result; a cancel gives none and retires at once.
// A stalled output holds the result; the input register still drains cancels
// and takes a new item the cycle the output register frees.
// Synchronous active-low reset clears all control state and loads the config regs with their defaults.

module button_scan_debounce_autorepeat
    import bsda_pkg::*;
#(
    parameter int BUTTON_COUNT = 8
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_button_sample,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_btn_held,
    output logic [7:0]  o_btn_press,
    output logic [7:0]  o_btn_release,
    output logic [7:0]  o_buttons_long,
    output logic        o_idle_expired,
    output logic [7:0]  o_last_pressed,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // sample bits past the last button are dropped on entry
    localparam logic [BTN_W-1:0] LANE_MASK = lane_mask(BUTTON_COUNT);

    t_cfg       cfg;
    t_result    core_result;

    logic       r_in_valid;
    logic       r_in_cancel;
    logic [7:0] r_in_sample;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       advance;
    logic       in_xfer;

    assign out_free   = !r_out_valid || i_out_ready;
    // cancels need no output slot
    assign advance    = r_in_valid && (r_in_cancel || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    bsda_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cancel <= (i_req_type == REQ_CANCEL);
            r_in_sample <= i_button_sample & LANE_MASK;
        end
    end

    bsda_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cancel (r_in_cancel),
        .i_sample (r_in_sample),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && !r_in_cancel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && !r_in_cancel) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_btn_held     = r_out.btn_held;
    assign o_btn_press    = r_out.btn_press;
    assign o_btn_release  = r_out.btn_release;
    assign o_buttons_long = r_out.buttons_long;
    assign o_idle_expired = r_out.idle_expired;
    assign o_last_pressed = r_out.last_pressed;

endmodule

// File: design/bsda_cfg.sv
`timescale 1ns / 1ps

module bsda_cfg
    import bsda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_mask         <= RST_BUTTON_MASK;
            r_cfg.autorepeat_mask     <= RST_AUTOREPEAT;
            r_cfg.filter_depth        <= RST_FILTER_DEPTH;
            r_cfg.long_press_ticks    <= RST_LONG_PRESS;
            r_cfg.repeat_first_delay  <= RST_FIRST_DELAY;
            r_cfg.repeat_start_period <= RST_START_PERIOD;
            r_cfg.repeat_min_period   <= RST_MIN_PERIOD;
            r_cfg.idle_timeout        <= RST_IDLE_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BUTTON_MASK:  r_cfg.button_mask         <= i_cfg_data[7:0];
                CFG_AUTOREPEAT:   r_cfg.autorepeat_mask     <= i_cfg_data[7:0];
                CFG_FILTER_DEPTH: r_cfg.filter_depth        <= i_cfg_data[3:0];
                CFG_LONG_PRESS:   r_cfg.long_press_ticks    <= i_cfg_data[7:0];
                CFG_FIRST_DELAY:  r_cfg.repeat_first_delay  <= i_cfg_data[7:0];
                CFG_START_PERIOD: r_cfg.repeat_start_period <= i_cfg_data[7:0];
                CFG_MIN_PERIOD:   r_cfg.repeat_min_period   <= i_cfg_data[7:0];
                CFG_IDLE_TIMEOUT: r_cfg.idle_timeout        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/bsda_core.sv
`timescale 1ns / 1ps

module bsda_core
    import bsda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_cancel,
    input  logic [7:0] i_sample,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic [7:0]  r_prev_sample,  n_prev_sample;
    logic [3:0]  r_filter_count, n_filter_count;
    logic [7:0]  r_stable_count, n_stable_count;
    logic [7:0]  r_press_en,     n_press_en;
    logic [7:0]  r_release_en,   n_release_en;
    logic [7:0]  r_repeat_count, n_repeat_count;
    logic [7:0]  r_repeat_period, n_repeat_period;
    logic [2:0]  r_accel_count,  n_accel_count;
    logic [7:0]  r_prev_stable,  n_prev_stable;
    logic [15:0] r_idle_count,   n_idle_count;
    logic [7:0]  r_held,         n_held;
    logic [7:0]  r_last_press,   n_last_press;

    logic [7:0]  btn, pressed, released, longp, rising, stable_inc, rc_dec;
    logic [2:0]  acc_dec;
    logic [15:0] idle_dec;
    logic        idle;

    always_comb begin
        n_prev_sample   = r_prev_sample;
        n_filter_count  = r_filter_count;
        n_stable_count  = r_stable_count;
        n_press_en      = r_press_en;
        n_release_en    = r_release_en;
        n_repeat_count  = r_repeat_count;
        n_repeat_period = r_repeat_period;
        n_accel_count   = r_accel_count;
        n_prev_stable   = r_prev_stable;
        n_idle_count    = r_idle_count;
        n_held          = r_held;
        n_last_press    = r_last_press;
        pressed    = '0;
        released   = '0;
        longp      = '0;
        idle       = 1'b0;
        btn        = i_sample & i_cfg.button_mask;
        rising     = (r_prev_stable ^ btn) & btn;
        stable_inc = (r_stable_count != 8'hFF) ? r_stable_count + 8'd1 : r_stable_count;
        rc_dec     = r_repeat_count - 8'd1;
        acc_dec    = r_accel_count - 3'd1;
        idle_dec   = r_idle_count - 16'd1;

        if (i_cancel) begin
            n_repeat_count = '0;
        end else begin
            if (r_prev_sample == btn) begin
                if (r_filter_count >= i_cfg.filter_depth) begin
                    n_held         = btn;
                    pressed        = btn & r_press_en;
                    released       = ~btn & r_release_en;
                    n_stable_count = stable_inc;
                    if (btn != '0) begin
                        n_idle_count = i_cfg.idle_timeout;
                        if (stable_inc > i_cfg.long_press_ticks) begin
                            longp          = btn;
                            n_stable_count = '0;
                            n_release_en   = '0;
                        end
                        if (r_repeat_count != '0) begin
                            n_repeat_count = rc_dec;
                            if (rc_dec == 8'd1 && (btn & i_cfg.autorepeat_mask) != '0) begin
                                pressed        = btn & i_cfg.autorepeat_mask;
                                n_repeat_count = r_repeat_period;
                                if (r_repeat_period > i_cfg.repeat_min_period) begin
                                    n_accel_count = acc_dec;
                                    if (acc_dec == '0) begin
                                        n_accel_count   = ACCEL_RELOAD;
                                        n_repeat_period = r_repeat_period - 8'd1;
                                    end
                                end
                            end
                        end else if ((pressed & i_cfg.autorepeat_mask) != '0) begin
                            n_repeat_count  = i_cfg.repeat_first_delay;
                            n_repeat_period = i_cfg.repeat_start_period;
                            n_accel_count   = ACCEL_FIRST;
                        end
                    end else begin
                        n_release_en = '0;
                        if (r_idle_count != '0) begin
                            n_idle_count = idle_dec;
                            idle         = (idle_dec == '0);
                        end
                    end
                    n_press_en = ~btn;
                    if (rising != '0) begin
                        n_release_en = rising;
                    end
                    n_prev_stable = btn;
                end else begin
                    n_filter_count = r_filter_count + 4'd1;
                end
            end else begin
                n_stable_count = '0;
                n_repeat_count = '0;
                n_filter_count = '0;
            end
            n_prev_sample = btn;
            if (pressed != '0) begin
                n_last_press = pressed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample   <= '0;
            r_filter_count  <= '0;
            r_stable_count  <= '0;
            r_press_en      <= '0;
            r_release_en    <= '0;
            r_repeat_count  <= '0;
            r_repeat_period <= '0;
            r_accel_count   <= '0;
            r_prev_stable   <= '0;
            r_idle_count    <= '0;
            r_held          <= '0;
            r_last_press    <= '0;
        end else if (i_en) begin
            r_prev_sample   <= n_prev_sample;
            r_filter_count  <= n_filter_count;
            r_stable_count  <= n_stable_count;
            r_press_en      <= n_press_en;
            r_release_en    <= n_release_en;
            r_repeat_count  <= n_repeat_count;
            r_repeat_period <= n_repeat_period;
            r_accel_count   <= n_accel_count;
            r_prev_stable   <= n_prev_stable;
            r_idle_count    <= n_idle_count;
            r_held          <= n_held;
            r_last_press    <= n_last_press;
        end
    end

    assign o_result.btn_held     = n_held;
    assign o_result.btn_press    = pressed;
    assign o_result.btn_release  = released;
    assign o_result.buttons_long = longp;
    assign o_result.idle_expired = idle;
    assign o_result.last_pressed = n_last_press;

endmodule

// File: design/bsda_checker.sv
`timescale 1ns / 1ps

module bsda_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_btn_held,
    input logic [7:0] i_btn_press,
    input logic [7:0] i_btn_release,
    input logic       i_idle_expired,
    input logic [7:0] i_last_pressed
);

    // a stalled result stays valid and keeps its press mask
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_btn_press))
        else $error("result dropped or changed under stall");

    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_btn_press & ~i_btn_held) == 8'd0)
        else $error("press reported for a button not held");

    a_release_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_btn_release & i_btn_held) == 8'd0)
        else $error("release reported for a held button");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_idle_expired |-> i_btn_held == 8'd0)
        else $error("idle timeout while a button is held");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_btn_press != 8'd0 |-> i_last_pressed == i_btn_press)
        else $error("last pressed mask not updated");

endmodule

bind button_scan_debounce_autorepeat bsda_checker u_bsda_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_btn_held     (o_btn_held),
    .i_btn_press    (o_btn_press),
    .i_btn_release  (o_btn_release),
    .i_idle_expired (o_idle_expired),
    .i_last_pressed (o_last_pressed)
);
